@@ hw/rtl/digit_key_chained_hash_table_top_defines.svh @@
// Assertion macros for the digit key chained hash table.
`ifndef DIGIT_KEY_CHAINED_HASH_TABLE_TOP_DEFINES_SVH
`define DIGIT_KEY_CHAINED_HASH_TABLE_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define DKCHT_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("dkcht invariant violated");

// Check that a trigger implies a condition in the next cycle.
`define DKCHT_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("dkcht sequence violated");

`endif

@@ hw/rtl/dkcht_pkg.sv @@
// Shared types and constants of the digit key chained hash table.
package dkcht_pkg;
   localparam int KEY_W    = 64;
   localparam int LEN_W    = 5;
   localparam int STATUS_W = 3;
   localparam int IDX_W    = 10;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   // Classified item handed from the front to the back.
   typedef struct packed {
      logic             func;
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] len;
      logic             bad;
   } dkcht_item_type;

   localparam int ITEM_W = $bits(dkcht_item_type);
endpackage

@@ hw/rtl/dkcht_req_if.sv @@
// Request channel interface of the hash table.
interface dkcht_req_if;
   import dkcht_pkg::*;
   logic             valid;
   logic             ready;
   logic             func;
   logic [KEY_W-1:0] key_digits;
   logic [LEN_W-1:0] key_length;
   logic             name_nonempty;
   modport source (output valid, func, key_digits, key_length, name_nonempty, input ready);
   modport sink (input valid, func, key_digits, key_length, name_nonempty, output ready);
endinterface

@@ hw/rtl/dkcht_rsp_if.sv @@
// Response channel interface of the hash table.
interface dkcht_rsp_if;
   import dkcht_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    entry_index;
   modport source (output valid, status, entry_index, input ready);
   modport sink (input valid, status, entry_index, output ready);
endinterface

@@ hw/rtl/dkcht_front.sv @@
// Front end: accept a request, check the key and fold its digits into a bucket.
module dkcht_front #(
   parameter int BUCKET_COUNT = 101,
   parameter int MAX_DIGITS   = 16,
   parameter int HW           = $clog2(BUCKET_COUNT)
) (
   input  logic                    clock,
   input  logic                    reset,
   dkcht_req_if.sink               req_if,
   output logic                    out_valid,
   input  logic                    out_full,
   output dkcht_pkg::dkcht_item_type out_item,
   output logic [HW-1:0]           out_bucket
);
   import dkcht_pkg::*;

   localparam int TW = HW + 6;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_HASH = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   fstate_type     state_ff, state_in;
   dkcht_item_type item_ff, item_in;
   logic [HW-1:0]  hash_ff, hash_in;
   logic [LEN_W-1:0] dig_ff, dig_in;

   logic [KEY_W-1:0] mkey;
   logic             key_ok;
   logic [3:0]       nib_idx;
   logic [3:0]       digit;
   logic [TW-1:0]    fold;

   // Mask unused nibbles and check the used ones.
   always_comb begin
      key_ok = (req_if.key_length != '0) &&
               (req_if.key_length <= LEN_W'(MAX_DIGITS));
      for (int i = 0; i < 16; i++) begin
         if (LEN_W'(i) < req_if.key_length) begin
            mkey[4*i +: 4] = req_if.key_digits[4*i +: 4];
            if (req_if.key_digits[4*i +: 4] > 4'd9) key_ok = 1'b0;
         end else begin
            mkey[4*i +: 4] = 4'h0;
         end
      end
   end

   // One digit per cycle: fold = (hash*31 + digit) mod BUCKET_COUNT.
   always_comb begin
      nib_idx = 4'(dig_ff - LEN_W'(1));
      digit   = 4'(item_ff.key >> {nib_idx, 2'b00});
      fold    = (TW'(hash_ff) << 5) - TW'(hash_ff) + TW'(digit);
      for (int k = 5; k >= 0; k--) begin
         if (fold >= (TW'(BUCKET_COUNT) << k)) fold = fold - (TW'(BUCKET_COUNT) << k);
      end
   end

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      hash_in  = hash_ff;
      dig_in   = dig_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_if.valid) begin
               item_in.func = req_if.func;
               item_in.key  = mkey;
               item_in.len  = req_if.key_length;
               item_in.bad  = !key_ok || (req_if.func == FUNC_INSERT && !req_if.name_nonempty);
               hash_in      = '0;
               dig_in       = req_if.key_length;
               state_in     = item_in.bad ? F_PUSH : F_HASH;
            end
         end
         F_HASH: begin
            hash_in = HW'(fold);
            dig_in  = dig_ff - LEN_W'(1);
            if (dig_ff == LEN_W'(1)) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!out_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff <= item_in;
      hash_ff <= hash_in;
      dig_ff  <= dig_in;
   end

   assign req_if.ready = (state_ff == F_IDLE);
   assign out_valid    = (state_ff == F_PUSH);
   assign out_item     = item_ff;
   assign out_bucket   = hash_ff;
endmodule

@@ hw/rtl/dkcht_queue.sv @@
// Two-entry queue between the front and the back.
module dkcht_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         empty
);
   logic [W-1:0] mem_ff [2];
   logic         wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push && !full) begin
         wr_in  = !wr_ff;
         cnt_in = cnt_in + 2'd1;
      end
      if (pop && !empty) begin
         rd_in  = !rd_ff;
         cnt_in = cnt_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push && !full) mem_ff[wr_ff] <= push_data;
   end
endmodule

@@ hw/rtl/dkcht_back.sv @@
// Back end: walk the bucket chain, insert nodes and drive the response.
module dkcht_back #(
   parameter int BUCKET_COUNT = 101,
   parameter int POOL_DEPTH   = 1024,
   parameter int HW           = $clog2(BUCKET_COUNT),
   parameter int NW           = $clog2(POOL_DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  dkcht_pkg::dkcht_item_type q_item,
   input  logic [HW-1:0]           q_bucket,
   output logic                    q_pop,
   dkcht_rsp_if.source             rsp_if
);
   import dkcht_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_HEAD = 4'b0010,
      B_NODE = 4'b0100,
      B_MISS = 4'b1000
   } bstate_type;

   bstate_type state_ff, state_in;
   dkcht_item_type item_ff;
   logic [HW-1:0]  bkt_ff;
   logic [NW:0]    cnt_ff;

   logic [NW-1:0]  bmem [BUCKET_COUNT];
   logic           bvld_ff [BUCKET_COUNT];
   logic [NW-1:0]  head_ff;
   logic           head_v_ff;

   logic [KEY_W-1:0] nkey_mem [POOL_DEPTH];
   logic [LEN_W-1:0] nlen_mem [POOL_DEPTH];
   logic [NW-1:0]    nnxt_mem [POOL_DEPTH];
   logic             nnv_mem  [POOL_DEPTH];
   logic [KEY_W-1:0] rkey_ff;
   logic [LEN_W-1:0] rlen_ff;
   logic [NW-1:0]    rnxt_ff;
   logic             rnv_ff;
   logic [NW-1:0]    ridx_ff;

   logic             rsp_v_ff;
   logic [STATUS_W-1:0] rsp_st_ff;
   logic [IDX_W-1:0] rsp_ix_ff;

   logic          start, hit, full, ins_we, rd_en, rsp_load;
   logic [NW-1:0] rd_addr;
   logic [STATUS_W-1:0] st_val;
   logic [NW-1:0] ix_val;
   logic [NW+IDX_W-1:0] ix_wide;

   assign start = (state_ff == B_IDLE) && !q_empty && !rsp_v_ff;
   assign q_pop = start;
   assign hit   = (rlen_ff == item_ff.len) && (rkey_ff == item_ff.key);
   assign full  = (cnt_ff == (NW+1)'(POOL_DEPTH));

   always_comb begin
      state_in = state_ff;
      rd_en    = 1'b0;
      rd_addr  = head_ff;
      ins_we   = 1'b0;
      rsp_load = 1'b0;
      st_val   = ST_OK;
      ix_val   = '0;
      unique case (state_ff)
         B_IDLE: begin
            if (start) begin
               if (q_item.bad) begin
                  rsp_load = 1'b1;
                  st_val   = (q_item.func == FUNC_SEARCH) ? ST_NOT_FOUND : ST_INVALID;
               end else begin
                  state_in = B_HEAD;
               end
            end
         end
         B_HEAD: begin
            if (head_v_ff) begin
               rd_en    = 1'b1;
               state_in = B_NODE;
            end else begin
               state_in = B_MISS;
            end
         end
         B_NODE: begin
            if (hit) begin
               rsp_load = 1'b1;
               st_val   = (item_ff.func == FUNC_SEARCH) ? ST_OK : ST_DUPLICATE;
               ix_val   = (item_ff.func == FUNC_SEARCH) ? ridx_ff : '0;
               state_in = B_IDLE;
            end else if (rnv_ff) begin
               rd_en   = 1'b1;
               rd_addr = rnxt_ff;
            end else begin
               state_in = B_MISS;
            end
         end
         B_MISS: begin
            rsp_load = 1'b1;
            state_in = B_IDLE;
            if (item_ff.func == FUNC_SEARCH) begin
               st_val = ST_NOT_FOUND;
            end else if (full) begin
               st_val = ST_FULL;
            end else begin
               ins_we = 1'b1;
               st_val = ST_OK;
               ix_val = cnt_ff[NW-1:0];
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign ix_wide = {{IDX_W{1'b0}}, ix_val};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         cnt_ff   <= '0;
         rsp_v_ff <= 1'b0;
         for (int i = 0; i < BUCKET_COUNT; i++) bvld_ff[i] <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ins_we) begin
            cnt_ff          <= cnt_ff + (NW+1)'(1);
            bvld_ff[bkt_ff] <= 1'b1;
         end
         if (rsp_load) rsp_v_ff <= 1'b1;
         else if (rsp_if.ready) rsp_v_ff <= 1'b0;
      end
      if (start) begin
         item_ff   <= q_item;
         bkt_ff    <= q_bucket;
         head_ff   <= bmem[q_bucket];
         head_v_ff <= bvld_ff[q_bucket];
      end
      if (ins_we) bmem[bkt_ff] <= cnt_ff[NW-1:0];
      if (rsp_load) begin
         rsp_st_ff <= st_val;
         rsp_ix_ff <= ix_wide[IDX_W-1:0];
      end
   end

   // Node pool: one write port at the count, one registered read port.
   always_ff @(posedge clock) begin
      if (ins_we) begin
         nkey_mem[cnt_ff[NW-1:0]] <= item_ff.key;
         nlen_mem[cnt_ff[NW-1:0]] <= item_ff.len;
         nnxt_mem[cnt_ff[NW-1:0]] <= head_ff;
         nnv_mem[cnt_ff[NW-1:0]]  <= head_v_ff;
      end
      if (rd_en) begin
         rkey_ff <= nkey_mem[rd_addr];
         rlen_ff <= nlen_mem[rd_addr];
         rnxt_ff <= nnxt_mem[rd_addr];
         rnv_ff  <= nnv_mem[rd_addr];
         ridx_ff <= rd_addr;
      end
   end

   assign rsp_if.valid       = rsp_v_ff;
   assign rsp_if.status      = rsp_st_ff;
   assign rsp_if.entry_index = rsp_ix_ff;
endmodule

@@ hw/rtl/digit_key_chained_hash_table_top.sv @@
// Top level of the digit key chained hash table.
// Usage:
//  - req_if carries one operation per transfer: func (0 insert, 1 search), the
//    key as packed BCD in key_digits with key_length digits, and name_nonempty.
//  - rsp_if returns exactly one transfer per request, in request order:
//    status (ok, not found, invalid, duplicate, full) and entry_index.
//  - The front takes a request while idle, folds one digit per cycle into
//    the bucket (none for a malformed key), then hands the item to the
//    two-entry queue, waiting while it is full, before taking another request.
//  - The back pops the item, reads the bucket head, then reads one
//    chain node per cycle through the registered node pool port, and in a
//    last step inserts, reports a miss or a full pool. A hit is answered
//    from the node step, and a malformed key right at the pop.
//  - The back pops its next item only after the response transfer, so it
//    works on one item at a time; front and back overlap and the slower
//    of the two sets the throughput.
//  - Reset clears the bucket valid bits and the entry count at once; no
//    clearing pass is needed. Node storage is left as is.
//  - When the receiver stalls the response register holds; the back stops
//    before its next item, the queue fills and then the front drops ready.
module digit_key_chained_hash_table_top #(
   parameter int BUCKET_COUNT = 101,
   parameter int POOL_DEPTH   = 1024,
   parameter int MAX_DIGITS   = 16
) (
   input logic          clock,
   input logic          reset,
   dkcht_req_if.sink    req_if,
   dkcht_rsp_if.source  rsp_if
);
   import dkcht_pkg::*;
`include "digit_key_chained_hash_table_top_defines.svh"

   localparam int HW = $clog2(BUCKET_COUNT);
   localparam int QW = ITEM_W + HW;

   logic           q_push, q_full, q_pop, q_empty;
   dkcht_item_type f_item, b_item;
   logic [HW-1:0]  f_bucket, b_bucket;
   logic [QW-1:0]  q_out;

   // Classify and hash.
   dkcht_front #(
      .BUCKET_COUNT(BUCKET_COUNT),
      .MAX_DIGITS(MAX_DIGITS)
   ) u_front (
      .clock(clock), .reset(reset), .req_if(req_if),
      .out_valid(q_push), .out_full(q_full),
      .out_item(f_item), .out_bucket(f_bucket)
   );

   // Decouple front from back.
   dkcht_queue #(.W(QW)) u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data({f_item, f_bucket}), .full(q_full),
      .pop(q_pop), .pop_data(q_out), .empty(q_empty)
   );

   assign b_item   = q_out[QW-1:HW];
   assign b_bucket = q_out[HW-1:0];

   // Walk chains and insert.
   dkcht_back #(
      .BUCKET_COUNT(BUCKET_COUNT),
      .POOL_DEPTH(POOL_DEPTH)
   ) u_back (
      .clock(clock), .reset(reset),
      .q_empty(q_empty), .q_item(b_item), .q_bucket(b_bucket), .q_pop(q_pop),
      .rsp_if(rsp_if)
   );

   // Only ok results carry an index.
   `DKCHT_ASSERT_ALWAYS(a_index_zero, clock, reset,
      !rsp_if.valid || rsp_if.status == ST_OK || rsp_if.entry_index == '0)
   // The back never pops an empty queue.
   `DKCHT_ASSERT_ALWAYS(a_no_empty_pop, clock, reset, !(q_pop && q_empty))
   // After a result is accepted, valid is low before any further result.
   `DKCHT_ASSERT_NEXT(a_rsp_gap, clock, reset, rsp_if.valid && rsp_if.ready, !rsp_if.valid)
endmodule
